/* design/psnl_pkg.sv */
// Shared types, field widths and codes for the priority sorted notify list.
package psnl_pkg;

  localparam int unsigned CmdW      = 2;
  localparam int unsigned IdW       = 16;
  localparam int unsigned PrioW     = 32;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned CountOutW = 5;

  localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdW-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CmdW-1:0] CMD_POP    = 2'd2;

  localparam logic [StatusW-1:0] ST_DONE = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL = 2'd1;
  localparam logic [StatusW-1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [IdW-1:0]          id;
    logic signed [PrioW-1:0] prio;
  } psnl_entry_t;

  // Operation broadcast to every cell of the chain at once.
  typedef struct packed {
    logic        ins_en;
    logic        rem_en;
    logic        pop_en;
    psnl_entry_t entry;
  } psnl_ctrl_t;

endpackage

/* design/psnl_if.sv */
// Request and response channel interfaces of the priority sorted notify list.
interface psnl_req_if;
  import psnl_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CmdW-1:0]         command;
  logic [IdW-1:0]          entry_id;
  logic signed [PrioW-1:0] priority_req;

  modport source (output valid, command, entry_id, priority_req, input ready);
  modport sink   (input valid, command, entry_id, priority_req, output ready);
endinterface

interface psnl_rsp_if;
  import psnl_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [StatusW-1:0]      status;
  logic [IdW-1:0]          taken_id;
  logic signed [PrioW-1:0] taken_priority;
  logic [CountOutW-1:0]    entry_count;
  logic [IdW-1:0]          head_id;
  logic signed [PrioW-1:0] head_priority;

  modport source (output valid, status, taken_id, taken_priority, entry_count,
                  head_id, head_priority, input ready);
  modport sink   (input valid, status, taken_id, taken_priority, entry_count,
                  head_id, head_priority, output ready);
endinterface

/* design/psnl_cell.sv */
// One slot of the sorted list: holds an entry and shifts with its neighbors.
module psnl_cell #(
  parameter int unsigned CountW = 5,
  parameter int unsigned Idx    = 0
) (
  input  logic                  clk_i,
  input  psnl_pkg::psnl_ctrl_t  ctrl_i,
  input  logic [CountW-1:0]     count_i,
  input  logic                  left_occ_i,
  input  logic                  left_gt_i,
  input  psnl_pkg::psnl_entry_t left_entry_i,
  input  psnl_pkg::psnl_entry_t right_entry_i,
  input  logic                  hit_i,
  output logic                  occ_o,
  output logic                  gt_o,
  output logic                  hit_o,
  output logic                  first_o,
  output psnl_pkg::psnl_entry_t entry_o,
  output psnl_pkg::psnl_entry_t entry_d_o
);
  import psnl_pkg::*;

  psnl_entry_t entry_q, entry_d;
  logic        match;

  assign occ_o   = (count_i > CountW'(Idx));
  assign gt_o    = occ_o && (ctrl_i.entry.prio > entry_q.prio);
  assign match   = occ_o && (entry_q.id == ctrl_i.entry.id);
  assign hit_o   = hit_i | match;
  assign first_o = match & ~hit_i;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins_en) begin
      // The new entry lands where the strictly-lower run begins; the run moves down.
      if (gt_o || (!occ_o && left_occ_i)) begin
        entry_d = left_gt_i ? left_entry_i : ctrl_i.entry;
      end
    end else if (ctrl_i.rem_en) begin
      if (hit_o) begin
        entry_d = right_entry_i;
      end
    end else if (ctrl_i.pop_en) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o   = entry_q;
  assign entry_d_o = entry_d;

endmodule

/* design/priority_sorted_notify_list.sv */
// Top level of the priority sorted notify list: a chain of list cells and a result register.
//
//   port   | direction | payload
//   -------+-----------+-------------------------------------------------------------
//   req_i  | in        | command, entry_id, priority_req
//   rsp_o  | out       | status, taken_id, taken_priority, entry_count, head_id,
//          |           | head_priority
//
// Every request is finished in the cycle it is accepted: all cells compare their own
// entry against the request at once and load their next entry at the same edge, so one
// request per cycle is taken unless the response stalls. The response register loads the
// result at that edge. A request is taken whenever the response register is empty or being
// drained, so a stalled response blocks only the next request. Reset empties the list at once.
module priority_sorted_notify_list #(
  parameter int unsigned LIST_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  psnl_req_if.sink         req_i,
  psnl_rsp_if.source       rsp_o
);
  import psnl_pkg::*;

  localparam int unsigned CountW = $clog2(LIST_DEPTH + 1);

  // Occupancy of the list. Cells below the count hold valid entries in order.
  logic [CountW-1:0] count_q, count_d;

  psnl_ctrl_t  ctrl;
  psnl_entry_t cell_entry   [LIST_DEPTH];
  psnl_entry_t cell_entry_d [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] cell_occ, cell_gt, cell_first;
  logic [LIST_DEPTH:0]   hit_chain;

  logic accept, full, empty, found;

  // Result register.
  logic                    rsp_valid_q;
  logic [StatusW-1:0]      status_q, status_d;
  psnl_entry_t             taken_q, taken_d;
  logic [CountOutW-1:0]    count_out_q;
  psnl_entry_t             head_q, head_d;

  assign req_i.ready = ~rsp_valid_q | rsp_o.ready;
  assign accept      = req_i.valid & req_i.ready;

  assign full  = (count_q == CountW'(LIST_DEPTH));
  assign empty = (count_q == '0);
  assign found = hit_chain[LIST_DEPTH];

  // Decode the request into the broadcast that every cell sees.
  always_comb begin
    ctrl             = '0;
    ctrl.entry.id    = req_i.entry_id;
    ctrl.entry.prio  = req_i.priority_req;
    if (accept) begin
      unique case (req_i.command)
        CMD_INSERT: ctrl.ins_en = ~full;
        CMD_REMOVE: ctrl.rem_en = 1'b1;
        CMD_POP:    ctrl.pop_en = ~empty;
        default:    ctrl = ctrl;
      endcase
    end
  end

  assign hit_chain[0] = 1'b0;

  // The chain itself. The first cell sees an always-occupied, never-lower neighbor on its
  // left; the last cell pulls its own entry from the right, which is never read again.
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    logic        left_occ, left_gt;
    psnl_entry_t left_entry, right_entry;

    if (g == 0) begin : g_first
      assign left_occ   = 1'b1;
      assign left_gt    = 1'b0;
      assign left_entry = ctrl.entry;
    end else begin : g_mid
      assign left_occ   = cell_occ[g-1];
      assign left_gt    = cell_gt[g-1];
      assign left_entry = cell_entry[g-1];
    end

    if (g == LIST_DEPTH - 1) begin : g_last
      assign right_entry = cell_entry[g];
    end else begin : g_inner
      assign right_entry = cell_entry[g+1];
    end

    psnl_cell #(
      .CountW (CountW),
      .Idx    (g)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .count_i       (count_q),
      .left_occ_i    (left_occ),
      .left_gt_i     (left_gt),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .hit_i         (hit_chain[g]),
      .occ_o         (cell_occ[g]),
      .gt_o          (cell_gt[g]),
      .hit_o         (hit_chain[g+1]),
      .first_o       (cell_first[g]),
      .entry_o       (cell_entry[g]),
      .entry_d_o     (cell_entry_d[g])
    );
  end

  // Work out the response and the new occupancy.
  always_comb begin
    psnl_entry_t match_entry;
    match_entry = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (cell_first[i]) begin
        match_entry = match_entry | cell_entry[i];
      end
    end

    status_d = ST_MISS;
    taken_d  = '0;
    count_d  = count_q;
    unique case (req_i.command)
      CMD_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_DONE;
          count_d  = count_q + CountW'(1);
        end
      end
      CMD_REMOVE: begin
        if (found) begin
          status_d = ST_DONE;
          taken_d  = match_entry;
          count_d  = count_q - CountW'(1);
        end
      end
      CMD_POP: begin
        if (!empty) begin
          status_d = ST_DONE;
          taken_d  = cell_entry[0];
          count_d  = count_q - CountW'(1);
        end
      end
      default: status_d = ST_MISS;
    endcase

    head_d = (count_d != '0) ? cell_entry_d[0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      taken_q     <= taken_d;
      count_out_q <= CountOutW'(count_d);
      head_q      <= head_d;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = status_q;
  assign rsp_o.taken_id       = taken_q.id;
  assign rsp_o.taken_priority = taken_q.prio;
  assign rsp_o.entry_count    = count_out_q;
  assign rsp_o.head_id        = head_q.id;
  assign rsp_o.head_priority  = head_q.prio;

endmodule

/* test/tb_priority_sorted_notify_list.sv */
// Self-checking testbench for the priority sorted notify list.
module tb_priority_sorted_notify_list;
  import psnl_pkg::*;

  localparam int unsigned LIST_DEPTH  = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 213;
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [StatusW-1:0]      status;
    logic [IdW-1:0]          taken_id;
    logic signed [PrioW-1:0] taken_priority;
    logic [CountOutW-1:0]    entry_count;
    logic [IdW-1:0]          head_id;
    logic signed [PrioW-1:0] head_priority;
  } list_result_t;

  // Mirrors the sorted list and queues the result each request should produce.
  class notify_list_scoreboard;
    logic [IdW-1:0]          held_ids[LIST_DEPTH];
    logic signed [PrioW-1:0] held_prios[LIST_DEPTH];
    int unsigned             held;
    list_result_t            expected_q[$];
    int unsigned             failures;

    function new();
      held     = 0;
      failures = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void drop_slot(int unsigned pos);
      for (int unsigned i = pos; i + 1 < held; i++) begin
        held_ids[i]   = held_ids[i + 1];
        held_prios[i] = held_prios[i + 1];
      end
      held--;
    endfunction

    function void note_request(logic [CmdW-1:0] cmd, logic [IdW-1:0] id,
                               logic signed [PrioW-1:0] prio);
      list_result_t exp;
      int unsigned  pos;
      exp = '0;
      exp.status = ST_MISS;
      case (cmd)
        CMD_INSERT: begin
          if (held >= LIST_DEPTH) begin
            exp.status = ST_FULL;
          end else begin
            // New entry goes ahead of the first strictly lower priority.
            pos = held;
            for (int unsigned i = 0; i < held; i++) begin
              if (prio > held_prios[i]) begin
                pos = i;
                break;
              end
            end
            for (int unsigned i = held; i > pos; i--) begin
              held_ids[i]   = held_ids[i - 1];
              held_prios[i] = held_prios[i - 1];
            end
            held_ids[pos]   = id;
            held_prios[pos] = prio;
            held++;
            exp.status = ST_DONE;
          end
        end
        CMD_REMOVE: begin
          for (int unsigned i = 0; i < held; i++) begin
            if (held_ids[i] == id) begin
              exp.taken_id       = held_ids[i];
              exp.taken_priority = held_prios[i];
              drop_slot(i);
              exp.status = ST_DONE;
              break;
            end
          end
        end
        CMD_POP: begin
          if (held > 0) begin
            exp.taken_id       = held_ids[0];
            exp.taken_priority = held_prios[0];
            drop_slot(0);
            exp.status = ST_DONE;
          end
        end
        default: begin
          // The unused command code leaves the list alone and reports a miss.
        end
      endcase
      exp.entry_count = CountOutW'(held);
      if (held > 0) begin
        exp.head_id       = held_ids[0];
        exp.head_priority = held_prios[0];
      end
      expected_q.push_back(exp);
    endfunction

    function void field_check(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
        failures++;
      end
    endfunction

    function void check_response(list_result_t got);
      list_result_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: response with no request outstanding, got %p", $time, got);
        failures++;
        return;
      end
      exp = expected_q.pop_front();
      field_check("status", 32'(exp.status), 32'(got.status));
      field_check("taken_id", 32'(exp.taken_id), 32'(got.taken_id));
      field_check("taken_priority", exp.taken_priority, got.taken_priority);
      field_check("entry_count", 32'(exp.entry_count), 32'(got.entry_count));
      field_check("head_id", 32'(exp.head_id), 32'(got.head_id));
      field_check("head_priority", exp.head_priority, got.head_priority);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned cycles    = 0;
  notify_list_scoreboard sb;

  psnl_req_if req_if ();
  psnl_rsp_if rsp_if ();

  priority_sorted_notify_list #(
    .LIST_DEPTH(LIST_DEPTH)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Requests are noted before responses so the order holds even for a zero-latency path.
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        sb.note_request(req_if.command, req_if.entry_id, req_if.priority_req);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        sb.check_response('{rsp_if.status, rsp_if.taken_id, rsp_if.taken_priority,
                            rsp_if.entry_count, rsp_if.head_id, rsp_if.head_priority});
      end
    end
  end

  task automatic send_request(input logic [CmdW-1:0] cmd, input logic [IdW-1:0] id,
                              input logic signed [PrioW-1:0] prio);
    int unsigned gap;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.command      <= cmd;
    req_if.entry_id     <= id;
    req_if.priority_req <= prio;
    do @(posedge clk); while (!req_if.ready);
  endtask

  function automatic logic [IdW-1:0] pick_id();
    // A small pool of ids makes removes hit held entries and creates duplicates.
    if ($urandom_range(0, 99) < 60) return IdW'($urandom_range(0, 15));
    return IdW'($urandom);
  endfunction

  function automatic logic signed [PrioW-1:0] pick_priority();
    int unsigned r;
    int          near_zero;
    r = $urandom_range(0, 99);
    near_zero = int'($urandom_range(0, 4)) - 2;
    if (r < 40) return near_zero;
    if (r < 50) return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    return $urandom;
  endfunction

  initial begin
    int unsigned idle_by_phase[4];
    int unsigned stall_by_phase[4];
    int unsigned mode;
    int unsigned r;
    logic [CmdW-1:0] cmd;

    idle_by_phase  = '{0, 48, 0, 34};
    stall_by_phase = '{0, 0, 48, 34};
    sb = new();
    rst_n               <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.command      <= CMD_INSERT;
    req_if.entry_id     <= '0;
    req_if.priority_req <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list: pop, remove and the unused code all report a miss.
    send_request(CMD_POP, 16'h1234, 32'sd99);
    send_request(CMD_REMOVE, 16'd5, 32'sd0);
    send_request(CMD_UNUSED, 16'hFFFF, 32'sh7FFF_FFFF);
    // Priority extremes, ties that keep arrival order and a duplicate id.
    send_request(CMD_INSERT, 16'hFFFF, 32'sh7FFF_FFFF);
    send_request(CMD_INSERT, 16'h0000, 32'sh8000_0000);
    send_request(CMD_INSERT, 16'd1, 32'sd0);
    send_request(CMD_INSERT, 16'd2, 32'sd0);
    send_request(CMD_INSERT, 16'd1, -32'sd1);
    // The first matching id goes; the priority field is ignored on remove.
    send_request(CMD_REMOVE, 16'd1, 32'sh8000_0000);
    send_request(CMD_REMOVE, 16'd7, 32'sh7FFF_FFFF);
    send_request(CMD_POP, 16'hABCD, -32'sd5);
    // Fill to capacity, then try one more insert and the unused code on a full list.
    for (int i = 0; i < 13; i++) send_request(CMD_INSERT, pick_id(), pick_priority());
    send_request(CMD_INSERT, 16'h00FF, 32'sh7FFF_FFFF);
    send_request(CMD_UNUSED, 16'd3, 32'sd3);

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_by_phase[phase];
      stall_pct = stall_by_phase[phase];
      mode = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Every forty requests switch between filling, draining and mixed traffic
        // so the list swings between empty and full many times.
        if (n % 40 == 0) mode = $urandom_range(0, 2);
        r = $urandom_range(0, 99);
        case (mode)
          0:       cmd = (r < 70) ? CMD_INSERT : (r < 85) ? CMD_REMOVE :
                         (r < 98) ? CMD_POP : CMD_UNUSED;
          1:       cmd = (r < 20) ? CMD_INSERT : (r < 60) ? CMD_REMOVE :
                         (r < 97) ? CMD_POP : CMD_UNUSED;
          default: cmd = (r < 45) ? CMD_INSERT : (r < 72) ? CMD_REMOVE :
                         (r < 97) ? CMD_POP : CMD_UNUSED;
        endcase
        send_request(cmd, pick_id(), pick_priority());
      end
    end
    req_if.valid <= 1'b0;
    // Wait until the last accepted request is already in the scoreboard.
    @(posedge clk);

    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/psnl_pkg.sv
design/psnl_if.sv
design/psnl_cell.sv
design/priority_sorted_notify_list.sv
test/tb_priority_sorted_notify_list.sv
